### hw/rtl/ssq_pkg.sv
// Shared types, constants and register indexes for the servo sweep sequencer.
// Used by the channel interfaces and every module of the block; no dependencies.
`default_nettype none

package ssq_pkg;

	localparam int unsigned ANGLE_W   = 8;
	localparam int unsigned AMP_W     = 8;
	localparam int unsigned REPEAT_W  = 7;
	localparam int unsigned PERIOD_W  = 16;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned STEP_W    = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned MAX_CMDS  = 5;
	localparam int unsigned CNT_W     = $clog2(MAX_CMDS + 1);
	localparam int unsigned IDX_W     = $clog2(MAX_CMDS);

	localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(180);

	localparam logic [ANGLE_W-1:0]  CENTER_RST = ANGLE_W'(90);
	localparam logic [AMP_W-1:0]    AMP_RST    = AMP_W'(30);
	localparam logic [REPEAT_W-1:0] REPEAT_RST = REPEAT_W'(3);
	localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(200);

	localparam logic [1:0] OP_TICK      = 2'd0;
	localparam logic [1:0] OP_REQUEST   = 2'd1;
	localparam logic [1:0] OP_CLEARANCE = 2'd2;

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_ATTACH = 2'd1;
	localparam logic [1:0] CMD_DETACH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AMP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd3;

	typedef struct packed {
		logic [ANGLE_W-1:0]  center_angle;
		logic [AMP_W-1:0]    swing_amplitude;
		logic [REPEAT_W-1:0] swing_repeats;
		logic [PERIOD_W-1:0] step_period_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [TIME_W-1:0] time_ms;
		logic              clearance;
	} item_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [ANGLE_W-1:0] angle;
	} servo_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		servo_cmd_t [MAX_CMDS-1:0] entry;
	} cmd_list_t;

endpackage

`default_nettype wire

### hw/rtl/ssq_if.sv
// Valid/ready channel interfaces for input items and servo commands.
// Depends on ssq_pkg for field widths.
`default_nettype none

interface ssq_in_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      opcode;
	logic [ssq_pkg::TIME_W-1:0]      time_ms;
	logic                            clearance;

	modport source (output valid, output opcode, output time_ms, output clearance, input ready);
	modport sink (input valid, input opcode, input time_ms, input clearance, output ready);
endinterface

interface ssq_out_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      command;
	logic [ssq_pkg::ANGLE_W-1:0]     angle;
	logic                            last;

	modport source (output valid, output command, output angle, output last, input ready);
	modport sink (input valid, input command, input angle, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/ssq_core.sv
// Sequencer state and per-item command generation for the servo sweep sequencer.
// Depends on ssq_pkg; produces the full command list of one item in one pass.
`default_nettype none

module ssq_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ssq_pkg::cfg_t      cfg,
	input  wire ssq_pkg::item_t     item,
	input  wire logic               advance,
	output ssq_pkg::cmd_list_t      list
);

	function automatic logic [ssq_pkg::ANGLE_W-1:0] clamp_angle(input logic signed [9:0] a);
		logic [ssq_pkg::ANGLE_W-1:0] r;
		if (a < 0) begin
			r = '0;
		end else if (a > $signed({2'b00, ssq_pkg::ANGLE_MAX})) begin
			r = ssq_pkg::ANGLE_MAX;
		end else begin
			r = a[ssq_pkg::ANGLE_W-1:0];
		end
		return r;
	endfunction

	logic                          allow_q, req_q, act_q, att_q;
	logic [ssq_pkg::TIME_W-1:0]    next_q;
	logic [ssq_pkg::STEP_W-1:0]    step_q;

	logic                          allow_n, req_n, act_n, att_n;
	logic [ssq_pkg::TIME_W-1:0]    next_n;
	logic [ssq_pkg::STEP_W-1:0]    step_n;

	logic [ssq_pkg::TIME_W-1:0]    sched;
	logic [ssq_pkg::TIME_W-1:0]    diff;
	logic [ssq_pkg::STEP_W-1:0]    total;
	logic [ssq_pkg::STEP_W-1:0]    final_idx;
	logic [ssq_pkg::STEP_W-1:0]    sc;
	logic signed [9:0]             c10, a10, target;
	logic [ssq_pkg::ANGLE_W-1:0]   center_c;
	logic                          stop;
	logic [ssq_pkg::CNT_W-1:0]     n;

	assign sched     = item.time_ms + ssq_pkg::TIME_W'(cfg.step_period_ms);
	assign final_idx = {cfg.swing_repeats, 1'b0};
	assign total     = final_idx + ssq_pkg::STEP_W'(1);
	assign c10       = $signed({2'b00, cfg.center_angle});
	assign a10       = $signed({2'b00, cfg.swing_amplitude});
	assign center_c  = clamp_angle(c10);

	always_comb begin
		allow_n = allow_q;
		req_n   = req_q;
		act_n   = act_q;
		att_n   = att_q;
		next_n  = next_q;
		step_n  = step_q;
		sc      = step_q;
		diff    = '0;
		target  = c10;
		stop    = 1'b0;
		n       = '0;
		list    = '0;
		unique case (item.opcode)
			ssq_pkg::OP_TICK: begin
				if (req_q && allow_q && !act_q) begin
					req_n = 1'b0;
					act_n = 1'b1;
					sc    = '0;
					if (!att_q) begin
						list.entry[n[ssq_pkg::IDX_W-1:0]] = '{ssq_pkg::CMD_ATTACH, '0};
						n = n + 1'b1;
					end
					att_n = 1'b1;
					list.entry[n[ssq_pkg::IDX_W-1:0]] = '{ssq_pkg::CMD_WRITE, center_c};
					n = n + 1'b1;
					next_n = sched;
				end
				diff = item.time_ms - next_n;
				if (act_n && !diff[ssq_pkg::TIME_W-1]) begin
					next_n = sched;
					if (sc >= total) begin
						stop = 1'b1;
					end else begin
						if (sc == final_idx) begin
							target = c10;
						end else if (!sc[0]) begin
							target = c10 + a10;
						end else begin
							target = c10 - a10;
						end
						if (att_n) begin
							list.entry[n[ssq_pkg::IDX_W-1:0]] =
								'{ssq_pkg::CMD_WRITE, clamp_angle(target)};
							n = n + 1'b1;
						end
						sc = sc + 1'b1;
						if (sc >= total) begin
							stop = 1'b1;
						end
					end
					if (stop) begin
						act_n = 1'b0;
						if (att_n) begin
							list.entry[n[ssq_pkg::IDX_W-1:0]] = '{ssq_pkg::CMD_WRITE, center_c};
							n = n + 1'b1;
							list.entry[n[ssq_pkg::IDX_W-1:0]] = '{ssq_pkg::CMD_DETACH, '0};
							n = n + 1'b1;
							att_n = 1'b0;
						end
					end
				end
				step_n = sc;
			end
			ssq_pkg::OP_REQUEST: begin
				req_n = 1'b1;
			end
			ssq_pkg::OP_CLEARANCE: begin
				allow_n = item.clearance;
				if (!item.clearance) begin
					req_n = 1'b0;
					act_n = 1'b0;
					if (att_q) begin
						if (act_q) begin
							list.entry[n[ssq_pkg::IDX_W-1:0]] = '{ssq_pkg::CMD_WRITE, center_c};
							n = n + 1'b1;
						end
						list.entry[n[ssq_pkg::IDX_W-1:0]] = '{ssq_pkg::CMD_DETACH, '0};
						n = n + 1'b1;
						att_n = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		list.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= 1'b0;
			req_q   <= 1'b0;
			act_q   <= 1'b0;
			att_q   <= 1'b0;
			next_q  <= '0;
			step_q  <= '0;
		end else if (advance) begin
			allow_q <= allow_n;
			req_q   <= req_n;
			act_q   <= act_n;
			att_q   <= att_n;
			next_q  <= next_n;
			step_q  <= step_n;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ssq_emit.sv
// Result register of the servo sweep sequencer: holds one item's command list
// and presents it one beat per cycle while the receiver is ready. Depends on ssq_pkg and ssq_out_if.
`default_nettype none

module ssq_emit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire ssq_pkg::cmd_list_t  list,
	output logic                     can_load,
	ssq_out_if.source                result
);

	ssq_pkg::servo_cmd_t [ssq_pkg::MAX_CMDS-1:0] ent_q;
	logic [ssq_pkg::CNT_W-1:0]                   rem_q;
	logic [ssq_pkg::IDX_W-1:0]                   idx_q;
	logic                                        pop;

	assign pop      = result.valid && result.ready;
	assign can_load = (rem_q == '0) || ((rem_q == ssq_pkg::CNT_W'(1)) && result.ready);

	assign result.valid   = (rem_q != '0);
	assign result.command = ent_q[idx_q].command;
	assign result.angle   = ent_q[idx_q].angle;
	assign result.last    = (rem_q == ssq_pkg::CNT_W'(1));

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= list.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= list.count;
			idx_q <= '0;
		end else if (pop) begin
			rem_q <= rem_q - 1'b1;
			idx_q <= (rem_q == ssq_pkg::CNT_W'(1)) ? '0 : idx_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/servo_sweep_sequencer.sv
// Top level of the servo sweep sequencer: configuration registers, input
// register and assertions. Depends on ssq_pkg, ssq_if, ssq_core and ssq_emit.
//
// Usage: input items (tick, run request, clearance) arrive as beats on the
// item channel; servo commands (write angle, attach, detach) leave as beats
// on the result channel, with last set on the final command of each item.
// Registers are written through cfg_we/cfg_index/cfg_data while the block is
// idle. An accepted item sits in the input register until the result register
// can load; then its whole command list (zero to five commands) is built in one
// pass and loaded into the result register, which presents its first command.
// Commands leave one per cycle while the receiver is ready. The next item waits
// in the input register meanwhile and moves on at the edge where the last
// command of the previous item leaves, so a new item is accepted in every
// cycle only while each item causes at most one command and the receiver is
// ready. When the receiver stalls, the result register holds its beat, the
// input register fills and item.ready falls. Reset clears all run state and
// flags and loads the register reset values.
`default_nettype none

module servo_sweep_sequencer (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [ssq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ssq_pkg::CFG_DATA_W-1:0]     cfg_data,
	ssq_in_if.sink                                  item,
	ssq_out_if.source                               result
);

	ssq_pkg::cfg_t      cfg_q;
	ssq_pkg::item_t     item_s1;
	logic               valid_s1;
	logic               advance;
	logic               can_load;
	ssq_pkg::cmd_list_t list;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_angle    <= ssq_pkg::CENTER_RST;
			cfg_q.swing_amplitude <= ssq_pkg::AMP_RST;
			cfg_q.swing_repeats   <= ssq_pkg::REPEAT_RST;
			cfg_q.step_period_ms  <= ssq_pkg::PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssq_pkg::REG_CENTER: cfg_q.center_angle <= cfg_data[ssq_pkg::ANGLE_W-1:0];
				ssq_pkg::REG_AMP:    cfg_q.swing_amplitude <= cfg_data[ssq_pkg::AMP_W-1:0];
				ssq_pkg::REG_REPEAT: cfg_q.swing_repeats <= cfg_data[ssq_pkg::REPEAT_W-1:0];
				ssq_pkg::REG_PERIOD: cfg_q.step_period_ms <= cfg_data[ssq_pkg::PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign advance    = valid_s1 && can_load;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.opcode    <= item.opcode;
			item_s1.time_ms   <= item.time_ms;
			item_s1.clearance <= item.clearance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	ssq_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item    (item_s1),
		.advance (advance),
		.list    (list)
	);

	ssq_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.list     (list),
		.can_load (can_load),
		.result   (result)
	);

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !can_load |-> !item.ready)
		else $error("Input accepted while the held item cannot move on.");

	a_list_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> list.count <= ssq_pkg::CNT_W'(ssq_pkg::MAX_CMDS))
		else $error("Command list longer than the result register.");

	a_detach_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.command == ssq_pkg::CMD_DETACH |-> result.last)
		else $error("Detach is not the final command of its item.");

	a_attach_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.command == ssq_pkg::CMD_ATTACH |-> !result.last)
		else $error("Attach is not followed by a center write.");

endmodule

`default_nettype wire

### tb/servo_sweep_sequencer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for servo_sweep_sequencer: drives item beats and register
// writes, predicts the servo command beats and checks them in order.
// Depends on ssq_pkg, the ssq_in_if/ssq_out_if interfaces and the RTL of the block.

module servo_sweep_sequencer_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 260;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		ssq_pkg::servo_cmd_t cmd;
		logic                last;
	} cmd_beat_t;

	class servo_cmd_tracker;
		logic [ssq_pkg::ANGLE_W-1:0]  center;
		logic [ssq_pkg::AMP_W-1:0]    amp;
		logic [ssq_pkg::REPEAT_W-1:0] repeats;
		logic [ssq_pkg::PERIOD_W-1:0] period;
		bit                           allowed;
		bit                           requested;
		bit                           active;
		bit                           attached;
		logic [ssq_pkg::TIME_W-1:0]   next_due;
		logic [ssq_pkg::STEP_W-1:0]   steps;
		cmd_beat_t                    pending_cmds[$];
		cmd_beat_t                    item_cmds[$];
		int                           mismatches;

		function new();
			center = ssq_pkg::CENTER_RST;
			amp = ssq_pkg::AMP_RST;
			repeats = ssq_pkg::REPEAT_RST;
			period = ssq_pkg::PERIOD_RST;
			allowed = 0;
			requested = 0;
			active = 0;
			attached = 0;
			next_due = '0;
			steps = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [ssq_pkg::CFG_IDX_W-1:0] idx,
				logic [ssq_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				ssq_pkg::REG_CENTER: center = data[ssq_pkg::ANGLE_W-1:0];
				ssq_pkg::REG_AMP:    amp = data[ssq_pkg::AMP_W-1:0];
				ssq_pkg::REG_REPEAT: repeats = data[ssq_pkg::REPEAT_W-1:0];
				ssq_pkg::REG_PERIOD: period = data[ssq_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [ssq_pkg::ANGLE_W-1:0] clamp_deg(int a);
			if (a < 0)
				return '0;
			if (a > int'(ssq_pkg::ANGLE_MAX))
				return ssq_pkg::ANGLE_MAX;
			return a[ssq_pkg::ANGLE_W-1:0];
		endfunction

		function void add_cmd(logic [1:0] command, logic [ssq_pkg::ANGLE_W-1:0] angle);
			cmd_beat_t b;
			b.cmd.command = command;
			b.cmd.angle = angle;
			b.last = 1'b0;
			item_cmds.push_back(b);
		endfunction

		function void stop_sweep();
			active = 0;
			if (attached) begin
				add_cmd(ssq_pkg::CMD_WRITE, clamp_deg(int'(center)));
				add_cmd(ssq_pkg::CMD_DETACH, '0);
				attached = 0;
			end
		endfunction

		function void tick(logic [ssq_pkg::TIME_W-1:0] now);
			logic [ssq_pkg::TIME_W-1:0] lag;
			int total;
			int target;
			if (requested && allowed && !active) begin
				requested = 0;
				active = 1;
				steps = '0;
				if (!attached) begin
					add_cmd(ssq_pkg::CMD_ATTACH, '0);
					attached = 1;
				end
				add_cmd(ssq_pkg::CMD_WRITE, clamp_deg(int'(center)));
				next_due = now + ssq_pkg::TIME_W'(period);
			end
			if (!active)
				return;
			lag = now - next_due;
			if (lag[ssq_pkg::TIME_W-1])
				return;
			next_due = now + ssq_pkg::TIME_W'(period);
			total = 2 * int'(repeats) + 1;
			if (int'(steps) >= total) begin
				stop_sweep();
				return;
			end
			if (int'(steps) == 2 * int'(repeats))
				target = int'(center);
			else if (!steps[0])
				target = int'(center) + int'(amp);
			else
				target = int'(center) - int'(amp);
			if (attached)
				add_cmd(ssq_pkg::CMD_WRITE, clamp_deg(target));
			steps = steps + 1'b1;
			if (int'(steps) >= total)
				stop_sweep();
		endfunction

		function void take_item(ssq_pkg::item_t it);
			item_cmds.delete();
			case (it.opcode)
				ssq_pkg::OP_TICK: tick(it.time_ms);
				ssq_pkg::OP_REQUEST: requested = 1;
				ssq_pkg::OP_CLEARANCE: begin
					allowed = it.clearance;
					if (!it.clearance) begin
						requested = 0;
						if (active)
							stop_sweep();
						if (attached) begin
							add_cmd(ssq_pkg::CMD_DETACH, '0);
							attached = 0;
						end
					end
				end
				default: ;
			endcase
			if (item_cmds.size() > 0)
				item_cmds[item_cmds.size() - 1].last = 1'b1;
			foreach (item_cmds[i])
				pending_cmds.push_back(item_cmds[i]);
		endfunction

		function void flag(string what, cmd_beat_t want, cmd_beat_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s: expected cmd %0d angle %0d last %0d, %s %0d %s %0d %s %0d",
					$time, what, want.cmd.command, want.cmd.angle, want.last,
					"got cmd", got.cmd.command, "angle", got.cmd.angle,
					"last", got.last);
		endfunction

		function void compare_beat(cmd_beat_t got);
			cmd_beat_t want;
			if (pending_cmds.size() == 0) begin
				want = '0;
				flag("unexpected command beat", want, got);
			end else begin
				want = pending_cmds.pop_front();
				if (got.cmd.command !== want.cmd.command || got.cmd.angle !== want.cmd.angle ||
						got.last !== want.last)
					flag("command beat differs", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [ssq_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ssq_pkg::CFG_DATA_W-1:0] cfg_data;
	int cycle_cnt = 0;
	bit send_idle = 0;
	bit recv_idle = 0;

	servo_cmd_tracker tracker = new();

	ssq_in_if item_ch();
	ssq_out_if result_ch();

	servo_sweep_sequencer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item_ch),
		.result(result_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] op, logic [ssq_pkg::TIME_W-1:0] t, logic clr);
		int gap;
		ssq_pkg::item_t it;
		gap = send_idle ? $urandom_range(0, 15) : 0;
		it.opcode = op;
		it.time_ms = t;
		it.clearance = clr;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= op;
		item_ch.time_ms <= t;
		item_ch.clearance <= clr;
		do
			@(posedge clk);
		while (!(item_ch.valid && item_ch.ready));
		tracker.take_item(it);
	endtask

	task automatic wait_idle(int extra);
		item_ch.valid <= 1'b0;
		while (tracker.pending_cmds.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic load_settings(int center, int amp, int reps, int per);
		logic [ssq_pkg::CFG_DATA_W-1:0] vals[4];
		logic [ssq_pkg::CFG_IDX_W-1:0] idx[4];
		vals[0] = ssq_pkg::CFG_DATA_W'(center);
		vals[1] = ssq_pkg::CFG_DATA_W'(amp);
		vals[2] = ssq_pkg::CFG_DATA_W'(reps);
		vals[3] = ssq_pkg::CFG_DATA_W'(per);
		idx[0] = ssq_pkg::REG_CENTER;
		idx[1] = ssq_pkg::REG_AMP;
		idx[2] = ssq_pkg::REG_REPEAT;
		idx[3] = ssq_pkg::REG_PERIOD;
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
			tracker.set_reg(idx[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_deg();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		if (r < 20)
			return 180;
		return $urandom_range(0, 180);
	endfunction

	initial begin
		cmd_beat_t got;
		int gap;
		forever begin
			gap = recv_idle ? $urandom_range(0, 15) : 0;
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(result_ch.valid && result_ch.ready));
			got.cmd.command = result_ch.command;
			got.cmd.angle = result_ch.angle;
			got.last = result_ch.last;
			tracker.compare_beat(got);
		end
	end

	initial begin
		logic [ssq_pkg::TIME_W-1:0] t0;
		logic [ssq_pkg::TIME_W-1:0] now_ms;
		int sent;
		int r;
		int per;
		int reps;
		int n;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.opcode <= ssq_pkg::OP_TICK;
		item_ch.time_ms <= '0;
		item_ch.clearance <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset register values.
		send_idle = 1;
		recv_idle = 0;
		t0 = $urandom_range(0, 32'h7fff_0000);
		send_item(OP_SPARE, $urandom, 1'b1);
		send_item(ssq_pkg::OP_CLEARANCE, $urandom, 1'b0);
		send_item(ssq_pkg::OP_REQUEST, $urandom, 1'b1);
		send_item(ssq_pkg::OP_TICK, t0, 1'b0);
		send_item(ssq_pkg::OP_CLEARANCE, $urandom, 1'b1);
		send_item(ssq_pkg::OP_CLEARANCE, $urandom, 1'b1);
		send_item(ssq_pkg::OP_TICK, t0 + 5, 1'b1);
		send_item(ssq_pkg::OP_REQUEST, $urandom, 1'b0);
		send_item(ssq_pkg::OP_TICK, t0 + 204, 1'b0);
		send_item(ssq_pkg::OP_TICK, t0 + 205, 1'b0);
		send_item(ssq_pkg::OP_TICK, t0 + 405, 1'b1);
		send_item(ssq_pkg::OP_CLEARANCE, $urandom, 1'b0);

		// Zero period and no repeats: start and final step land in one tick.
		wait_idle(SETTLE_CYCLES);
		load_settings(0, 180, 0, 0);
		send_idle = 0;
		recv_idle = 1;
		send_item(ssq_pkg::OP_CLEARANCE, $urandom, 1'b1);
		send_item(ssq_pkg::OP_REQUEST, $urandom, 1'b0);
		send_item(ssq_pkg::OP_TICK, $urandom, 1'b0);

		// Top of the angle range with the longest period across the time wrap.
		wait_idle(SETTLE_CYCLES);
		load_settings(180, 180, 1, 65535);
		recv_idle = 0;
		send_item(ssq_pkg::OP_REQUEST, $urandom, 1'b1);
		send_item(ssq_pkg::OP_TICK, 32'hffff_ff00, 1'b0);
		send_item(ssq_pkg::OP_TICK, 32'hffff_ffff, 1'b0);
		send_item(ssq_pkg::OP_TICK, 32'h0000_feff, 1'b0);
		send_item(ssq_pkg::OP_TICK, 32'h0001_fefe, 1'b0);
		send_item(ssq_pkg::OP_TICK, 32'h0002_fefd, 1'b0);
		send_item(ssq_pkg::OP_TICK, 32'h0003_fefc, 1'b0);

		sent = 0;
		now_ms = $urandom;
		while (sent < RANDOM_ITEMS) begin
			wait_idle(SETTLE_CYCLES);
			r = $urandom_range(0, 99);
			reps = (r < 5) ? 127 : (r < 12) ? 0 : $urandom_range(0, 4);
			r = $urandom_range(0, 99);
			per = (r < 8) ? 0 : (r < 13) ? 65535 : $urandom_range(1, 300);
			load_settings(pick_deg(), pick_deg(), reps, per);
			send_idle = 1'($urandom_range(0, 1));
			recv_idle = 1'($urandom_range(0, 1));
			send_item(ssq_pkg::OP_CLEARANCE, $urandom, 1'b1);
			send_item(ssq_pkg::OP_REQUEST, $urandom, 1'($urandom_range(0, 1)));
			sent += 2;
			n = $urandom_range(25, 45);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					now_ms = now_ms + ssq_pkg::TIME_W'($urandom_range(0, 2 * per + 1));
					send_item(ssq_pkg::OP_TICK, now_ms, 1'($urandom_range(0, 1)));
				end else if (r < 70) begin
					send_item(ssq_pkg::OP_REQUEST, $urandom, 1'($urandom_range(0, 1)));
				end else if (r < 78) begin
					send_item(ssq_pkg::OP_CLEARANCE, $urandom, 1'b1);
				end else if (r < 83) begin
					send_item(ssq_pkg::OP_CLEARANCE, $urandom, 1'b0);
				end else if (r < 88) begin
					send_item(OP_SPARE, $urandom, 1'($urandom_range(0, 1)));
					sent--;
				end else if (r < 93) begin
					now_ms = $urandom;
					send_item(ssq_pkg::OP_TICK, now_ms, 1'($urandom_range(0, 1)));
				end else begin
					send_item(ssq_pkg::OP_TICK,
						now_ms - ssq_pkg::TIME_W'($urandom_range(1, 1000)), 1'b0);
				end
				sent++;
			end
		end

		wait_idle(20);
		if (tracker.mismatches == 0 && tracker.pending_cmds.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
